/* design/a2d_pkg.sv */
// ----------------------------------------------------------------------------
// a2d_pkg: shared definitions for the analog stick to dpad block
// Control word layout, microcode program, operation and jump codes, fixed
// arithmetic constants and the octant to direction mask table.
// ----------------------------------------------------------------------------
package a2d_pkg;

   // Configuration register indexes
   localparam logic CSR_DEADZONE = 1'b0;
   localparam logic CSR_SWITCH   = 1'b1;

   // Reset values of the configuration registers
   localparam logic [14:0] DEADZONE_RESET = 15'd10000;
   localparam logic [15:0] SWITCH_RESET   = 16'd16000;

   // Axis codes of an input beat
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   // Arctangent coefficient b in Q16 and angle arithmetic constants
   localparam logic [15:0] ATAN_B      = 16'd39075;
   localparam logic [18:0] HALF_TURN   = 19'd131072;
   localparam logic [18:0] FULL_TURN   = 19'd262144;
   localparam logic [18:0] ANGLE_ROUND = 19'd512;
   localparam logic [7:0]  OCT_OFFSET  = 8'd80;
   localparam logic [4:0]  DIV_LAST    = 5'd16;

   // Datapath operation codes
   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_MUL_XX   = 4'd1;
   localparam logic [3:0] OP_MUL_YY   = 4'd2;
   localparam logic [3:0] OP_MUL_XY   = 4'd3;
   localparam logic [3:0] OP_MUL_RR   = 4'd4;
   localparam logic [3:0] OP_MUL_BA   = 4'd5;
   localparam logic [3:0] OP_NUM      = 4'd6;
   localparam logic [3:0] OP_DEN      = 4'd7;
   localparam logic [3:0] OP_DIV_INIT = 4'd8;
   localparam logic [3:0] OP_DIV      = 4'd9;
   localparam logic [3:0] OP_FIN      = 4'd10;
   localparam logic [3:0] OP_ZERO     = 4'd11;

   // Jump condition codes
   localparam logic [1:0] JMP_NONE     = 2'd0;
   localparam logic [1:0] JMP_INSIDE   = 2'd1;
   localparam logic [1:0] JMP_DEN_ZERO = 2'd2;
   localparam logic [1:0] JMP_LOOP     = 2'd3;

   // Program addresses that are jump targets
   localparam logic [3:0] PC_DIV  = 4'd9;
   localparam logic [3:0] PC_FIN  = 4'd10;
   localparam logic [3:0] PC_ZERO = 4'd11;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] jmp;
      logic [3:0] target;
      logic       last;
   } uword_type;

   typedef struct packed {
      logic in_zone;
      logic den_zero;
      logic cnt_nz;
   } dp_status_type;

   localparam uword_type NOP_WORD = '{op: OP_NOP, jmp: JMP_NONE, target: 4'd0, last: 1'b0};

   // Microcode program: one control word per step.
   function automatic uword_type ucode_rom(input logic [3:0] pc);
      uword_type w;
      w = NOP_WORD;
      case (pc)
         4'd0: w.op = OP_MUL_XX;
         4'd1: w.op = OP_MUL_YY;
         4'd2: w.op = OP_MUL_XY;
         4'd3: w.op = OP_MUL_RR;
         4'd4: begin
            w.op     = OP_MUL_BA;
            w.jmp    = JMP_INSIDE;
            w.target = PC_ZERO;
         end
         4'd5: w.op = OP_NUM;
         4'd6: w.op = OP_DEN;
         4'd7: w.op = OP_DIV_INIT;
         4'd8: begin
            w.jmp    = JMP_DEN_ZERO;
            w.target = PC_FIN;
         end
         4'd9: begin
            w.op     = OP_DIV;
            w.jmp    = JMP_LOOP;
            w.target = PC_DIV;
         end
         4'd10: begin
            w.op   = OP_FIN;
            w.last = 1'b1;
         end
         default: begin
            w.op   = OP_ZERO;
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

   // Octant to direction mask: bit0 up, bit1 down, bit2 left, bit3 right.
   function automatic logic [3:0] octant_mask(input logic [2:0] oct);
      logic [3:0] m;
      case (oct)
         3'd0: m = 4'd1;
         3'd1: m = 4'd9;
         3'd2: m = 4'd8;
         3'd3: m = 4'd10;
         3'd4: m = 4'd2;
         3'd5: m = 4'd6;
         3'd6: m = 4'd4;
         default: m = 4'd5;
      endcase
      return m;
   endfunction

endpackage

/* design/a2d_seq.sv */
// ----------------------------------------------------------------------------
// a2d_seq: microcode sequencer
// Step counter over the program table with conditional jumps; holds on the
// final step until the result register can take the new beat.
// ----------------------------------------------------------------------------
module a2d_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start_i,
   input  logic                  out_free_i,
   input  a2d_pkg::dp_status_type status_i,
   output a2d_pkg::uword_type    ctl_o,
   output logic                  busy_o,
   output logic                  done_o
);

   logic [3:0]         pc_ff;
   logic [3:0]         pc_in;
   logic               busy_ff;
   logic               busy_in;
   a2d_pkg::uword_type uw;
   logic               take_jump;

   assign uw = a2d_pkg::ucode_rom(pc_ff);

   // Evaluate the jump condition of the current step.
   always_comb begin
      case (uw.jmp)
         a2d_pkg::JMP_NONE:     take_jump = 1'b0;
         a2d_pkg::JMP_INSIDE:   take_jump = status_i.in_zone;
         a2d_pkg::JMP_DEN_ZERO: take_jump = status_i.den_zero;
         a2d_pkg::JMP_LOOP:     take_jump = status_i.cnt_nz;
         default:               take_jump = 1'b0;
      endcase
   end

   assign done_o = busy_ff && uw.last && out_free_i;
   assign ctl_o  = busy_ff ? uw : a2d_pkg::NOP_WORD;
   assign busy_o = busy_ff;

   // Next step and run flag.
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start_i) begin
         pc_in   = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (uw.last) begin
            if (out_free_i) begin
               busy_in = 1'b0;
            end
         end else if (take_jump) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= 4'd0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* design/a2d_dp.sv */
// ----------------------------------------------------------------------------
// a2d_dp: arithmetic datapath
// One shared 16x31 multiplier, adders for numerator and denominator, a
// restoring divider stepped one quotient bit per cycle and the angle mapper.
// ----------------------------------------------------------------------------
module a2d_dp (
   input  logic                   clock,
   input  a2d_pkg::uword_type     ctl_i,
   input  logic [15:0]            x_i,
   input  logic [15:0]            y_i,
   input  logic [14:0]            radius_i,
   output a2d_pkg::dp_status_type status_o,
   output logic [3:0]             mask_o
);

   logic [15:0] ax;
   logic [15:0] ay;
   logic [15:0] mul_a;
   logic [30:0] mul_b;
   logic [46:0] prod;

   logic [30:0] xx_ff;
   logic [30:0] yy_ff;
   logic [30:0] a_ff;
   logic [29:0] rad2_ff;
   logic [45:0] ba_ff;
   logic [46:0] num_ff;
   logic [47:0] den_ff;
   logic [48:0] rem_ff;
   logic [16:0] q_ff;
   logic [4:0]  cnt_ff;

   logic [31:0] mag2;
   logic        ge;
   logic [48:0] rem_sub;
   logic [18:0] r_ext;
   logic [18:0] turn;
   logic [18:0] turn_rnd;
   logic [7:0]  oct_sum;

   // Magnitudes of the stored axes.
   assign ax = x_i[15] ? (~x_i + 16'd1) : x_i;
   assign ay = y_i[15] ? (~y_i + 16'd1) : y_i;

   // Shared multiplier operand selection.
   always_comb begin
      case (ctl_i.op)
         a2d_pkg::OP_MUL_XX: begin
            mul_a = ax;
            mul_b = 31'(ax);
         end
         a2d_pkg::OP_MUL_YY: begin
            mul_a = ay;
            mul_b = 31'(ay);
         end
         a2d_pkg::OP_MUL_XY: begin
            mul_a = ax;
            mul_b = 31'(ay);
         end
         a2d_pkg::OP_MUL_RR: begin
            mul_a = {1'b0, radius_i};
            mul_b = 31'(radius_i);
         end
         a2d_pkg::OP_MUL_BA: begin
            mul_a = a2d_pkg::ATAN_B;
            mul_b = a_ff;
         end
         default: begin
            mul_a = 16'd0;
            mul_b = 31'd0;
         end
      endcase
   end

   assign prod = 47'(mul_a) * 47'(mul_b);

   // Deadzone test and loop status.
   assign mag2              = 32'(xx_ff) + 32'(yy_ff);
   assign status_o.in_zone  = mag2 < 32'(rad2_ff);
   assign status_o.den_zero = den_ff == 48'd0;
   assign status_o.cnt_nz   = cnt_ff != 5'd0;

   // One restoring division step.
   assign ge      = rem_ff >= {1'b0, den_ff};
   assign rem_sub = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   // Registers written by the current operation. The denominator is built as
   // b*A plus x*x in Q16, and the numerator is added on the next step.
   always_ff @(posedge clock) begin
      case (ctl_i.op)
         a2d_pkg::OP_MUL_XX: xx_ff   <= prod[30:0];
         a2d_pkg::OP_MUL_YY: yy_ff   <= prod[30:0];
         a2d_pkg::OP_MUL_XY: a_ff    <= prod[30:0];
         a2d_pkg::OP_MUL_RR: rad2_ff <= prod[29:0];
         a2d_pkg::OP_MUL_BA: ba_ff   <= prod[45:0];
         a2d_pkg::OP_NUM: num_ff <= 47'(ba_ff) + {yy_ff, 16'd0};
         a2d_pkg::OP_DEN: den_ff <= 48'(ba_ff) + {1'b0, xx_ff, 16'd0};
         a2d_pkg::OP_DIV_INIT: begin
            den_ff <= den_ff + 48'(num_ff);
            rem_ff <= 49'(num_ff);
            q_ff   <= 17'd0;
            cnt_ff <= a2d_pkg::DIV_LAST;
         end
         a2d_pkg::OP_DIV: begin
            rem_ff <= {rem_sub[47:0], 1'b0};
            q_ff   <= {q_ff[15:0], ge};
            cnt_ff <= cnt_ff - 5'd1;
         end
         default: begin
         end
      endcase
   end

   // Quadrant offset, rounding to 1/256 turn and octant lookup.
   assign r_ext = 19'(q_ff);
   always_comb begin
      case ({x_i[15], y_i[15]})
         2'b00:   turn = r_ext;
         2'b10:   turn = a2d_pkg::HALF_TURN - r_ext;
         2'b11:   turn = a2d_pkg::HALF_TURN + r_ext;
         default: turn = a2d_pkg::FULL_TURN - r_ext;
      endcase
   end
   assign turn_rnd = turn + a2d_pkg::ANGLE_ROUND;
   assign oct_sum  = turn_rnd[17:10] + a2d_pkg::OCT_OFFSET;

   assign mask_o = (ctl_i.op == a2d_pkg::OP_FIN) ? a2d_pkg::octant_mask(oct_sum[7:5]) : 4'd0;

endmodule

/* design/analog_stick_to_dpad.sv */
// ----------------------------------------------------------------------------
// analog_stick_to_dpad: left stick events to an eight-way direction mask
// Result path: an x or y beat runs the program through the 17-step divider loop;
// inside the deadzone it jumps to the zero step, and with the stick centered and
// outside a zero radius it skips the divider. Input stalls while a beat runs;
// other axes or ignored pads are taken one per cycle when idle, no result.
// Reset: synchronous; owner and stored axes clear, registers take defaults.
// ----------------------------------------------------------------------------
module analog_stick_to_dpad (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_pad_id,
   input  logic [1:0]         req_axis_code,
   input  logic signed [15:0] req_axis_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_direction_mask,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wr_data
);

   logic [14:0] deadzone_ff;
   logic [15:0] switch_ff;
   logic [7:0]  owner_ff;
   logic [15:0] x_ff;
   logic [15:0] y_ff;
   logic        rsp_valid_ff;
   logic [3:0]  rsp_mask_ff;

   logic        req_accept;
   logic        is_x;
   logic        is_y;
   logic        foreign;
   logic [15:0] value_abs;
   logic        take;
   logic        out_free;
   logic        busy;
   logic        done;
   logic [3:0]  dp_mask;

   a2d_pkg::uword_type     ctl;
   a2d_pkg::dp_status_type status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= a2d_pkg::DEADZONE_RESET;
         switch_ff   <= a2d_pkg::SWITCH_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == a2d_pkg::CSR_DEADZONE) begin
            deadzone_ff <= csr_wr_data[14:0];
         end else begin
            switch_ff <= csr_wr_data;
         end
      end
   end

   // Input beat filtering: other axes and weak events from other pads drop.
   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;
   assign is_x       = req_axis_code == a2d_pkg::AXIS_X;
   assign is_y       = req_axis_code == a2d_pkg::AXIS_Y;
   assign foreign    = req_pad_id != owner_ff;
   assign value_abs  = req_axis_value[15] ? (~req_axis_value + 16'd1) : req_axis_value;
   assign take       = req_accept && (is_x || is_y) && !(foreign && (value_abs < switch_ff));

   // Owner and stored axis positions.
   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= 8'd0;
         x_ff     <= 16'd0;
         y_ff     <= 16'd0;
      end else if (take) begin
         owner_ff <= req_pad_id;
         if (is_x) begin
            x_ff <= req_axis_value;
         end else if (foreign) begin
            x_ff <= 16'd0;
         end
         if (is_y) begin
            y_ff <= req_axis_value;
         end else if (foreign) begin
            y_ff <= 16'd0;
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   a2d_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start_i    (take),
      .out_free_i (out_free),
      .status_i   (status),
      .ctl_o      (ctl),
      .busy_o     (busy),
      .done_o     (done)
   );

   a2d_dp u_dp (
      .clock    (clock),
      .ctl_i    (ctl),
      .x_i      (x_ff),
      .y_i      (y_ff),
      .radius_i (deadzone_ff),
      .status_o (status),
      .mask_o   (dp_mask)
   );

   // Result register: holds one beat while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_mask_ff <= dp_mask;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_direction_mask = rsp_mask_ff;

endmodule

/* design/a2d_checker.sv */
// ----------------------------------------------------------------------------
// a2d_checker: port-level checks for the analog stick to dpad block
// Watches the handshakes and result beats and is bound to the top level.
// ----------------------------------------------------------------------------
module a2d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_axis_code,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_direction_mask
);

   // A stalled result beat stays and keeps its mask.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_direction_mask)))
      else $error("result beat changed while stalled");

   // No result beat is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // A beat of another axis never starts the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_axis_code[1]) |=> !req_stall)
      else $error("other axis beat blocked the input");

   // The input blocks only after a beat was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stalled without an accepted beat");

   // A direction never points both ways on one axis.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_direction_mask[0] && rsp_direction_mask[1])
                     && !(rsp_direction_mask[2] && rsp_direction_mask[3])))
      else $error("contradictory direction mask");

endmodule

bind analog_stick_to_dpad a2d_checker u_a2d_checker (.*);
